// ===== hdl/shadow_memory_access_checker_assert.svh =====
// assertion macros for the shadow memory access checker
// no dependencies; included by the top level only
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_ASSERT_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMAC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("smac assertion failed");
`define SMAC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("smac forbidden condition seen");
`else
`define SMAC_ASSERT(lbl, clk, rstn, prop)
`define SMAC_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hdl/smac_pkg.sv =====
// shared types and constants for the shadow memory access checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package smac_pkg;

    localparam int ADDR_W     = 19;
    localparam int LEN_W      = 20;
    localparam int PV_W       = 8;
    localparam int GRAN_SHIFT = 3;
    localparam int GRAN_SIZE  = 1 << GRAN_SHIFT;
    localparam int GRAN_W     = ADDR_W - GRAN_SHIFT;
    localparam int CNT_W      = GRAN_W + 1;
    localparam int END_W      = ADDR_W + 1;
    localparam int SUM_W      = LEN_W + 1;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;

    typedef enum logic [1:0] {
        ACT_CHECK    = 2'd0,
        ACT_POISON   = 2'd1,
        ACT_UNPOISON = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ACC_B1 = 2'd0,
        ACC_B4 = 2'd1,
        ACC_B8 = 2'd2
    } t_acc;

    typedef enum logic [1:0] {
        OP_CHECK,
        OP_FILL,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_HEAD,
        S_FILL,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [GRAN_W-1:0] idx;
        logic [2:0]        offset;
        logic [1:0]        code;
        logic              head_en;
        logic [PV_W-1:0]   head_val;
        logic [GRAN_W-1:0] body_idx;
        logic [CNT_W-1:0]  body_cnt;
        logic [PV_W-1:0]   body_val;
        logic              accepted;
    } t_cmd;

    typedef struct packed {
        logic clear_busy;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== hdl/smac_front.sv =====
// front end: accepts requests and turns them into granule commands
// depends on smac_pkg
`timescale 1ns / 1ps
`default_nettype none
module smac_front
    import smac_pkg::*;
(
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_action,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [LEN_W-1:0]  i_length,
    input  wire logic [PV_W-1:0]   i_poison_value,
    input  wire logic [1:0]        i_access_code,
    input  wire t_back_stat        i_stat,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    localparam logic [SUM_W-1:0] WIN_SUM = SUM_W'(1) << ADDR_W;

    logic [SUM_W-1:0]        sum;
    logic [END_W-1:0]        end_b;
    logic [END_W-1:0]        u_span;
    logic [GRAN_SHIFT-1:0]   off;
    logic [GRAN_W-1:0]       a_g;
    logic [CNT_W-1:0]        end_g;
    logic [GRAN_SHIFT:0]     rem;
    logic                    unal;
    logic                    short_rng;
    logic [CNT_W-1:0]        ps_g;
    logic [CNT_W-1:0]        p_cnt;
    logic [CNT_W-1:0]        u_cnt;

    assign o_ready = !i_q_full && !i_stat.clear_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        sum    = {{(SUM_W-ADDR_W){1'b0}}, i_address} + {{(SUM_W-LEN_W){1'b0}}, i_length};
        // clamp the range end to the window
        end_b  = (sum > WIN_SUM) ? WIN_SUM[END_W-1:0] : sum[END_W-1:0];
        off    = i_address[GRAN_SHIFT-1:0];
        a_g    = i_address[ADDR_W-1:GRAN_SHIFT];
        end_g  = end_b[END_W-1:GRAN_SHIFT];
        unal   = (off != '0);
        rem    = (GRAN_SHIFT+1)'(GRAN_SIZE) - {1'b0, off};
        short_rng = unal && (i_length < LEN_W'(rem));
        ps_g   = {1'b0, a_g} + CNT_W'(unal);
        p_cnt  = end_g - ps_g;
        // unpoison steps by 8 from the start: one granule per started 8 bytes
        u_span = end_b - {1'b0, i_address} + END_W'(GRAN_SIZE - 1);
        u_cnt  = u_span[END_W-1:GRAN_SHIFT];
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.idx      = a_g;
        o_cmd.offset   = off;
        o_cmd.code     = i_access_code;
        o_cmd.accepted = 1'b1;
        case (t_action'(i_action))
            ACT_CHECK: begin
                o_cmd.op = OP_CHECK;
            end
            ACT_POISON: begin
                if (short_rng) begin
                    o_cmd.accepted = 1'b0;
                end else begin
                    o_cmd.op       = OP_FILL;
                    o_cmd.head_en  = unal;
                    o_cmd.head_val = {{(PV_W-GRAN_SHIFT){1'b0}}, off};
                    o_cmd.body_idx = ps_g[GRAN_W-1:0];
                    o_cmd.body_cnt = p_cnt;
                    o_cmd.body_val = i_poison_value;
                end
            end
            ACT_UNPOISON: begin
                o_cmd.op       = OP_FILL;
                o_cmd.body_idx = a_g;
                o_cmd.body_cnt = u_cnt;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/smac_queue.sv =====
// two-entry command queue between front end and back end
// depends on smac_pkg
`timescale 1ns / 1ps
`default_nettype none
module smac_queue
    import smac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (Q_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/smac_back.sv =====
// back end: shadow store, clearing pass, granule fills, checks, result register
// depends on smac_pkg
`timescale 1ns / 1ps
`default_nettype none
module smac_back
    import smac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_cmd i_q_cmd,
    output logic      o_pop,
    output t_back_stat o_stat,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic      o_fault,
    output logic      o_accepted
);

    localparam int DEPTH = 1 << GRAN_W;

    logic [PV_W-1:0]   r_mem [DEPTH];
    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic [GRAN_W-1:0] r_clr_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [GRAN_W-1:0] r_widx;
    logic [PV_W-1:0]   r_rd_data;
    logic              r_out_valid;
    logic              r_fault;
    logic              r_acc;

    logic              mem_we;
    logic [GRAN_W-1:0] mem_waddr;
    logic [PV_W-1:0]   mem_wdata;
    logic              clr_step;
    logic              fill_step;
    logic              out_free;
    logic              out_load;
    logic              fault_eval;
    logic [3:0]        width;
    logic [3:0]        reach;

    assign out_free      = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_fault       = r_fault;
    assign o_accepted    = r_acc;
    assign o_stat.clear_busy = (r_state == S_CLEAR);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_cmd.op)
                        OP_CHECK: n_state = S_READ;
                        OP_FILL:  n_state = S_HEAD;
                        default:  n_state = S_RESULT;
                    endcase
                end
            end
            S_READ:  n_state = S_RESULT;
            S_HEAD:  n_state = S_FILL;
            S_FILL: begin
                if (r_cnt == '0) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = r_cmd.body_val;
        clr_step  = 1'b0;
        fill_step = 1'b0;
        o_pop     = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                clr_step  = 1'b1;
            end
            S_IDLE: begin
                o_pop = !i_q_empty;
            end
            S_HEAD: begin
                mem_we    = r_cmd.head_en;
                mem_waddr = r_cmd.idx;
                mem_wdata = r_cmd.head_val;
            end
            S_FILL: begin
                mem_we    = (r_cnt != '0);
                fill_step = (r_cnt != '0);
            end
            S_RESULT: begin
                out_load = out_free;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // access check against the signed shadow byte
    always_comb begin
        case (t_acc'(r_cmd.code))
            ACC_B1:  width = 4'd1;
            ACC_B4:  width = 4'd4;
            default: width = 4'd0;
        endcase
        reach = {1'b0, r_cmd.offset} + width;
        if (r_rd_data == '0) begin
            fault_eval = 1'b0;
        end else if (width == 4'd0) begin
            fault_eval = 1'b1;
        end else begin
            fault_eval = $signed({5'b0, reach}) > $signed({r_rd_data[PV_W-1], r_rd_data});
        end
        if (r_cmd.op != OP_CHECK) begin
            fault_eval = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_step) begin
                r_clr_idx <= r_clr_idx + GRAN_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_q_cmd;
            r_cnt  <= i_q_cmd.body_cnt;
            r_widx <= i_q_cmd.body_idx;
        end else if (fill_step) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_widx <= r_widx + GRAN_W'(1);
        end
        if (out_load) begin
            r_fault <= fault_eval;
            r_acc   <= r_cmd.accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_cmd.idx];
    end

endmodule
`default_nettype wire

// ===== hdl/shadow_memory_access_checker.sv =====
// shadow memory access checker, top level
// uses smac_pkg, smac_front, smac_queue, smac_back and the assertion header
//
// usage:
// - request channel i_valid / o_ready carries action, address, length,
//   poison value and access code; result channel o_valid / i_ready carries
//   fault and accepted, exactly one result per request, in request order
// - one shadow byte per 8-byte granule, 65536 granules in a store with one
//   write port and one registered read port
// - a check holds the back end through dequeue (S_IDLE), store read (S_READ)
//   and result load (S_RESULT), in that order
// - poison and unpoison pass dequeue, S_HEAD and S_FILL, which fills N granules
//   one per cycle, then the result load; S_HEAD writes a poison's partial start granule
// - refused poison and unused actions go from dequeue straight to the result load
// - the front end classifies a request in its accept cycle and parks it in a
//   two-entry queue, so requests keep being taken while the back end works
//   or a result waits in the output register
// - after reset the back end runs a clearing pass over all 65536 granules that
//   zeroes the store; o_ready stays low throughout it
// - when the receiver holds i_ready low the result stays put, the back end
//   waits with the next result and the queue fills, then o_ready drops
`timescale 1ns / 1ps
`default_nettype none
`include "shadow_memory_access_checker_assert.svh"
module shadow_memory_access_checker
    import smac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_action,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [LEN_W-1:0]  i_length,
    input  wire logic [PV_W-1:0]   i_poison_value,
    input  wire logic [1:0]        i_access_code,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_fault,
    output logic                   o_accepted
);

    // front to queue
    logic       q_push;
    logic       q_full;
    t_cmd       front_cmd;
    // queue to back
    logic       q_pop;
    logic       q_empty;
    t_cmd       q_cmd;
    // back status, clearing pass in progress
    t_back_stat stat;

    smac_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_length       (i_length),
        .i_poison_value (i_poison_value),
        .i_access_code  (i_access_code),
        .i_stat         (stat),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    smac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    smac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_cmd),
        .o_pop      (q_pop),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_fault    (o_fault),
        .o_accepted (o_accepted)
    );

    // no request may enter while the store is still being cleared
    `SMAC_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n, (i_valid && o_ready) |-> !stat.clear_busy)
    // no result can exist before the clearing pass is over
    `SMAC_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, stat.clear_busy |-> !o_valid)
    // the front end never overruns the queue
    `SMAC_NEVER(a_push_when_full, i_clk, i_rst_n, q_push && q_full)
    // the back end never dequeues from an empty queue
    `SMAC_NEVER(a_pop_when_empty, i_clk, i_rst_n, q_pop && q_empty)

endmodule
`default_nettype wire
